/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
// Both sample on clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// ante at a clock edge means cons holds from that edge on (cons may open with a delay)
`define AST_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("projector assertion failed");
// ante at a clock edge means cons holds at the next edge
`define AST_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("projector assertion failed");
`endif

/* design/ppp_pkg.sv */
`timescale 1ns / 1ps
package ppp_pkg;

	localparam int COORD_WIDTH  = 16;
	localparam int FRAC_BITS    = 12;
	localparam int ANGLE_WIDTH  = 16;
	localparam int NUM_REGS     = 8;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_FRAC  = 30;

	localparam int IDX_W  = $clog2(NUM_REGS);
	localparam int ADDR_W = IDX_W + 2;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(CORDIC_STEPS);

	// CORDIC datapath: x/y in Q30 with headroom, z in turn units with sign
	localparam int CX_W = CORDIC_FRAC + 4;
	localparam int CZ_W = 33;

	// rotation entries are about +-1.0, transformed coordinates stay within a few
	// times the coordinate range
	localparam int ROT_W   = FRAC_BITS + 3;
	localparam int V_W     = COORD_WIDTH + 4;
	localparam int PROD_W  = ROT_W + COORD_WIDTH;
	localparam int DVD_W   = V_W + FRAC_BITS;
	localparam int DIV_STAGES = DVD_W;
	// accept edge to the edge that samples the result strobe
	localparam int LATENCY = DIV_STAGES + 5;

	localparam int FIFO_DEPTH = 2;

	localparam logic [IDX_W-1:0] REG_BOX_LENGTH  = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_BOX_HEIGHT  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_BOX_DEPTH   = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_CAMERA_X    = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_CAMERA_Y    = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_CAMERA_Z    = IDX_W'(5);
	localparam logic [IDX_W-1:0] REG_YAW_ANGLE   = IDX_W'(6);
	localparam logic [IDX_W-1:0] REG_PITCH_ANGLE = IDX_W'(7);

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_DEPTH = 2'd2;

	localparam logic [COORD_WIDTH-2:0] BOX_RST   = (COORD_WIDTH-1)'(4096);
	localparam logic [COORD_WIDTH-1:0] CAM_X_RST = COORD_WIDTH'(0);
	localparam logic [COORD_WIDTH-1:0] CAM_Y_RST = COORD_WIDTH'(0);
	localparam logic [COORD_WIDTH-1:0] CAM_Z_RST = COORD_WIDTH'(6554);
	localparam logic [ANGLE_WIDTH-1:0] YAW_RST   = ANGLE_WIDTH'(5461);
	localparam logic [ANGLE_WIDTH-1:0] PITCH_RST = ANGLE_WIDTH'(910);

	localparam logic signed [CX_W-1:0] CORDIC_GAIN = CX_W'(652032874);

	typedef logic signed [ROT_W-1:0] rot_t;
	typedef logic signed [V_W-1:0]   vec_t;

	typedef struct packed {
		logic [2:0][COORD_WIDTH-2:0] box;
		logic [2:0][COORD_WIDTH-1:0] cam;
		logic [ANGLE_WIDTH-1:0]      yaw;
		logic [ANGLE_WIDTH-1:0]      pitch;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic [8:0][ROT_W-1:0] rot;
		logic [2:0][V_W-1:0]   trans;
	} matrix_t;

	typedef struct packed {
		logic [2:0][V_W-1:0] v;
		logic                bad;
	} vec_item_t;

	// atan(2^-i) as a fraction of a full turn of 2^32
	function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41721;
			5'd15: r = 32'd20860;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2607;
			5'd19: r = 32'd1303;
			5'd20: r = 32'd651;
			5'd21: r = 32'd325;
			5'd22: r = 32'd162;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	function automatic logic [V_W-1:0] vec_mag(input logic signed [V_W-1:0] v);
		return v[V_W-1] ? V_W'(-v) : V_W'(v);
	endfunction

endpackage

/* design/ppp_matrix.sv */
`timescale 1ns / 1ps
module ppp_matrix import ppp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t wr,
	output cfg_t    cfg,
	output matrix_t mtx,
	output logic    building
);

	typedef enum logic [4:0] {
		B_IDLE   = 5'b00001,
		B_CORDIC = 5'b00010,
		B_ROT    = 5'b00100,
		B_TPROD  = 5'b01000,
		B_TSUM   = 5'b10000
	} bstate_t;

	localparam int RSH = CORDIC_FRAC - FRAC_BITS;
	localparam logic signed [CX_W-1:0]     CRND = CX_W'(1) <<< (RSH - 1);
	localparam logic signed [2*ROT_W-1:0]  PRND = (2*ROT_W)'(1) <<< (FRAC_BITS - 1);
	localparam logic signed [PROD_W+1:0]   TRND = (PROD_W+2)'(1) <<< (FRAC_BITS - 1);

	bstate_t state_q;
	logic    pend_q;
	logic    sel_q;
	logic [CNT_W-1:0] cnt_q;
	cfg_t    cfg_q;
	matrix_t mtx_q;

	logic signed [CX_W-1:0] cx_q, cy_q;
	logic signed [CZ_W-1:0] cz_q;
	logic [1:0] quad_q;
	rot_t ct_q, st_q, cp_q, sp_q;
	logic signed [PROD_W-1:0] tp_q [9];

	logic signed [CX_W-1:0] dx, dy, x_nx, y_nx, xr, yr;
	logic signed [CZ_W-1:0] at, z_nx;
	rot_t xq, yq, c_nx, s_nx;
	logic [31:0] a_yaw, a_pitch;
	logic signed [COORD_WIDTH-1:0] h [3];
	logic last;

	assign cfg = cfg_q;
	assign mtx = mtx_q;
	assign building = pend_q | (state_q != B_IDLE);
	assign last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	assign a_yaw   = {cfg_q.yaw,   {(32-ANGLE_WIDTH){1'b0}}};
	assign a_pitch = {cfg_q.pitch, {(32-ANGLE_WIDTH){1'b0}}};

	always_comb begin
		dx = cy_q >>> cnt_q;
		dy = cx_q >>> cnt_q;
		at = $signed({1'b0, atan_turn(cnt_q)});
		if (!cz_q[CZ_W-1]) begin
			x_nx = cx_q - dx;
			y_nx = cy_q + dy;
			z_nx = cz_q - at;
		end else begin
			x_nx = cx_q + dx;
			y_nx = cy_q - dy;
			z_nx = cz_q + at;
		end
		xr = (x_nx + CRND) >>> RSH;
		yr = (y_nx + CRND) >>> RSH;
		xq = ROT_W'(xr);
		yq = ROT_W'(yr);
		case (quad_q)
			2'd0: begin
				c_nx = xq;
				s_nx = yq;
			end
			2'd1: begin
				c_nx = -yq;
				s_nx = xq;
			end
			2'd2: begin
				c_nx = -xq;
				s_nx = -yq;
			end
			default: begin
				c_nx = yq;
				s_nx = -xq;
			end
		endcase
		for (int j = 0; j < 3; j++) begin
			h[j] = -$signed({2'b00, cfg_q.box[j][COORD_WIDTH-2:1]});
		end
	end

	// register file: bits above a register's width drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box   <= {BOX_RST, BOX_RST, BOX_RST};
			cfg_q.cam   <= {CAM_Z_RST, CAM_Y_RST, CAM_X_RST};
			cfg_q.yaw   <= YAW_RST;
			cfg_q.pitch <= PITCH_RST;
		end else if (wr.en) begin
			case (wr.idx)
				REG_BOX_LENGTH:  cfg_q.box[0] <= wr.data[COORD_WIDTH-2:0];
				REG_BOX_HEIGHT:  cfg_q.box[1] <= wr.data[COORD_WIDTH-2:0];
				REG_BOX_DEPTH:   cfg_q.box[2] <= wr.data[COORD_WIDTH-2:0];
				REG_CAMERA_X:    cfg_q.cam[0] <= wr.data[COORD_WIDTH-1:0];
				REG_CAMERA_Y:    cfg_q.cam[1] <= wr.data[COORD_WIDTH-1:0];
				REG_CAMERA_Z:    cfg_q.cam[2] <= wr.data[COORD_WIDTH-1:0];
				REG_YAW_ANGLE:   cfg_q.yaw    <= wr.data[ANGLE_WIDTH-1:0];
				REG_PITCH_ANGLE: cfg_q.pitch  <= wr.data[ANGLE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pend_q  <= 1'b1;
			sel_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			pend_q <= wr.en | (pend_q & (state_q != B_IDLE));
			case (state_q)
				B_IDLE: begin
					if (pend_q) begin
						state_q <= B_CORDIC;
						sel_q   <= 1'b0;
						cnt_q   <= '0;
					end
				end
				B_CORDIC: begin
					if (last) begin
						cnt_q <= '0;
						sel_q <= 1'b1;
						if (sel_q) state_q <= B_ROT;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				B_ROT:   state_q <= B_TPROD;
				B_TPROD: state_q <= B_TSUM;
				B_TSUM:  state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				cz_q   <= CZ_W'(a_yaw[29:0]);
				quad_q <= a_yaw[31:30];
			end
			B_CORDIC: begin
				if (last) begin
					cx_q   <= CORDIC_GAIN;
					cy_q   <= '0;
					cz_q   <= CZ_W'(a_pitch[29:0]);
					quad_q <= a_pitch[31:30];
					if (!sel_q) begin
						ct_q <= c_nx;
						st_q <= s_nx;
					end else begin
						cp_q <= c_nx;
						sp_q <= s_nx;
					end
				end else begin
					cx_q <= x_nx;
					cy_q <= y_nx;
					cz_q <= z_nx;
				end
			end
			B_ROT: begin
				mtx_q.rot[0] <= ROT_W'((ct_q * cp_q + PRND) >>> FRAC_BITS);
				mtx_q.rot[1] <= ROT_W'((ct_q * sp_q + PRND) >>> FRAC_BITS);
				mtx_q.rot[2] <= st_q;
				mtx_q.rot[3] <= -sp_q;
				mtx_q.rot[4] <= cp_q;
				mtx_q.rot[5] <= '0;
				mtx_q.rot[6] <= ROT_W'((PRND - st_q * cp_q) >>> FRAC_BITS);
				mtx_q.rot[7] <= ROT_W'((PRND - st_q * sp_q) >>> FRAC_BITS);
				mtx_q.rot[8] <= ct_q;
			end
			B_TPROD: begin
				for (int k = 0; k < 9; k++) begin
					tp_q[k] <= PROD_W'($signed(mtx_q.rot[k]) * h[k % 3]);
				end
			end
			B_TSUM: begin
				// the translation is bounded well inside V_W, so no clamp is needed
				for (int r = 0; r < 3; r++) begin
					mtx_q.trans[r] <= V_W'(((PROD_W+2)'(tp_q[3*r]) + (PROD_W+2)'(tp_q[3*r+1])
						+ (PROD_W+2)'(tp_q[3*r+2]) + TRND) >>> FRAC_BITS)
						+ V_W'($signed(cfg_q.cam[r]));
				end
			end
			default: ;
		endcase
	end

endmodule

/* design/ppp_front.sv */
`timescale 1ns / 1ps
module ppp_front import ppp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  matrix_t                       mtx,
	output logic                          push,
	output vec_item_t                     item
);

	localparam int S_W = PROD_W + 2;
	localparam logic signed [S_W-1:0] RND = S_W'(1) <<< (FRAC_BITS - 1);

	logic signed [COORD_WIDTH-1:0] p [3];
	logic signed [PROD_W-1:0] prod_s1 [9];
	logic vld_s1, vld_s2;
	vec_item_t item_s2;
	logic signed [S_W-1:0] acc [3];
	vec_t v [3];

	assign p[0] = point_x;
	assign p[1] = point_y;
	assign p[2] = point_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = S_W'(prod_s1[3*r]) + S_W'(prod_s1[3*r+1]) + S_W'(prod_s1[3*r+2]) + RND;
			v[r] = V_W'(acc[r] >>> FRAC_BITS) + $signed(mtx.trans[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			prod_s1[k] <= PROD_W'($signed(mtx.rot[k]) * p[k % 3]);
		end
		for (int r = 0; r < 3; r++) begin
			item_s2.v[r] <= v[r];
		end
		// classify: depth not positive skips the projection
		item_s2.bad <= v[2][V_W-1] | (v[2] == '0);
	end

	assign push = vld_s2;
	assign item = item_s2;

endmodule

/* design/ppp_fifo.sv */
`timescale 1ns / 1ps
module ppp_fifo import ppp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  vec_item_t din,
	input  logic      pop,
	output vec_item_t dout,
	output logic      empty
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	vec_item_t mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;
	logic full, do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (PTR_W+1)'(FIFO_DEPTH));
	assign do_pop  = pop & ~empty;
	assign do_push = push & (~full | do_pop);
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PTR_W'(1);
			if (do_pop)  rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

endmodule

/* design/ppp_back.sv */
`timescale 1ns / 1ps
module ppp_back import ppp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  vec_item_t                     item,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic [1:0]                    status
);

	localparam int N = DIV_STAGES;
	localparam logic [DVD_W-1:0] LIM = DVD_W'(1) << (COORD_WIDTH - 1);

	logic [1:0][V_W-1:0]   rem_s [N+1];
	logic [1:0][DVD_W-1:0] dvd_s [N+1];
	logic [V_W-1:0]        den_s [N+1];
	logic [1:0]            neg_s [N+1];
	logic                  bad_s [N+1];
	logic                  vld_s [N+1];

	logic done_q;
	logic [1:0][COORD_WIDTH-1:0] scr_q;
	logic [1:0] status_q;
	logic [1:0][COORD_WIDTH-1:0] res;
	logic [1:0] sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else         vld_s[0] <= in_vld;
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 2; l++) begin
			rem_s[0][l] <= '0;
			dvd_s[0][l] <= {vec_mag($signed(item.v[l])), {FRAC_BITS{1'b0}}};
			neg_s[0][l] <= item.v[l][V_W-1];
		end
		den_s[0] <= item.bad ? V_W'(1) : item.v[2];
		bad_s[0] <= item.bad;
	end

	// restoring divider, one quotient bit per stage; the dividend word fills with the quotient
	for (genvar k = 0; k < N; k++) begin : g_div
		logic [1:0][V_W:0] trial;
		logic [1:0]        ge;
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = {rem_s[k][l], dvd_s[k][l][DVD_W-1]};
				ge[l] = (trial[l] >= {1'b0, den_s[k]});
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else         vld_s[k+1] <= vld_s[k];
		end
		always_ff @(posedge clk) begin
			for (int l = 0; l < 2; l++) begin
				rem_s[k+1][l] <= ge[l] ? V_W'(trial[l] - {1'b0, den_s[k]}) : V_W'(trial[l]);
				dvd_s[k+1][l] <= {dvd_s[k][l][DVD_W-2:0], ge[l]};
			end
			den_s[k+1] <= den_s[k];
			neg_s[k+1] <= neg_s[k];
			bad_s[k+1] <= bad_s[k];
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			if (!neg_s[N][l]) begin
				sat[l] = dvd_s[N][l] > (LIM - DVD_W'(1));
				res[l] = sat[l] ? COORD_WIDTH'(LIM - DVD_W'(1)) : COORD_WIDTH'(dvd_s[N][l]);
			end else begin
				sat[l] = dvd_s[N][l] > LIM;
				res[l] = sat[l] ? COORD_WIDTH'(-LIM) : COORD_WIDTH'(-dvd_s[N][l]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= vld_s[N];
	end

	always_ff @(posedge clk) begin
		if (bad_s[N]) begin
			scr_q    <= '0;
			status_q <= ST_DEPTH;
		end else begin
			scr_q    <= res;
			status_q <= (|sat) ? ST_SAT : ST_OK;
		end
	end

	assign done     = done_q;
	assign screen_x = $signed(scr_q[0]);
	assign screen_y = $signed(scr_q[1]);
	assign status   = status_q;

endmodule

/* design/perspective_point_projector_unit.sv */
`timescale 1ns / 1ps
// Perspective point projector. Pulse start with a point while busy is low and the
// point is taken at that edge; one point can be taken every cycle while busy stays low.
// Each point comes back as a single-cycle done strobe with screen_x, screen_y and
// status; the receiver cannot stall, so capture the result on the strobe.
// On its way a point passes a product register, a sum and classify register, a queue
// slot, a divider load register, a 32-stage restoring divider (one quotient bit per
// stage) and an output register. busy is high after reset and after every register
// write while the 3x4 matrix is rebuilt: a 24-step CORDIC for yaw and then pitch,
// followed by the rotation, product and sum steps. Write registers only while no
// point is in flight.
module perspective_point_projector_unit import ppp_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] screen_x,
	output logic signed [COORD_WIDTH-1:0] screen_y,
	output logic [1:0]                    status,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [DATA_W-1:0]             pwdata,
	output logic [DATA_W-1:0]             prdata,
	output logic                          pready
);

	cfg_wr_t   wr;
	cfg_t      cfg;
	matrix_t   mtx;
	logic      building;
	logic      accept;
	logic      push, empty;
	vec_item_t front_item, queue_item;

	// registers sit on word addresses; the write lands on the access cycle
	assign pready  = 1'b1;
	assign wr.en   = psel & penable & pwrite & pready;
	assign wr.idx  = paddr[ADDR_W-1:2];
	assign wr.data = pwdata;

	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_BOX_LENGTH:  prdata = DATA_W'(cfg.box[0]);
			REG_BOX_HEIGHT:  prdata = DATA_W'(cfg.box[1]);
			REG_BOX_DEPTH:   prdata = DATA_W'(cfg.box[2]);
			REG_CAMERA_X:    prdata = DATA_W'(cfg.cam[0]);
			REG_CAMERA_Y:    prdata = DATA_W'(cfg.cam[1]);
			REG_CAMERA_Z:    prdata = DATA_W'(cfg.cam[2]);
			REG_YAW_ANGLE:   prdata = DATA_W'(cfg.yaw);
			REG_PITCH_ANGLE: prdata = DATA_W'(cfg.pitch);
			default:         prdata = '0;
		endcase
	end

	// hold off new points only while the matrix is rebuilt
	assign busy   = building;
	assign accept = start & ~building;

	ppp_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.cfg      (cfg),
		.mtx      (mtx),
		.building (building)
	);

	// front: transform and flag points whose depth is not positive
	ppp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (accept),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.mtx     (mtx),
		.push    (push),
		.item    (front_item)
	);

	// the back end never stalls, so drain the queue whenever it holds a transfer
	ppp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_item),
		.pop    (~empty),
		.dout   (queue_item),
		.empty  (empty)
	);

	// back: divide by depth, saturate, drive the result strobe
	ppp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (~empty),
		.item     (queue_item),
		.done     (done),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.status   (status)
	);

endmodule

/* design/ppp_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ppp_checker import ppp_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic signed [COORD_WIDTH-1:0] screen_x,
	input logic signed [COORD_WIDTH-1:0] screen_y,
	input logic [1:0]                    status,
	input logic                          psel,
	input logic                          penable,
	input logic                          pwrite
);

	// a register write starts a rebuild
	`AST_NEXT(a_write_busy, psel && penable && pwrite, busy)
	// every accepted point returns after the fixed latency
	`AST_IMPLY(a_latency, start && !busy, ##LATENCY done)
	// a point behind the camera reads as zero
	`AST_IMPLY(a_depth_zero, done && status == ST_DEPTH, screen_x == '0 && screen_y == '0)

endmodule

bind perspective_point_projector_unit ppp_checker u_ppp_checker (.*);

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the perspective point projector.
// A local model rebuilds the 3x4 world matrix from the register shadow and
// projects every accepted point; a monitor compares each done strobe with the
// oldest projection. Phases sweep register settings and sender idling.
module tb_top;
	import ppp_pkg::*;

	typedef struct {
		logic signed [COORD_WIDTH-1:0] sx;
		logic signed [COORD_WIDTH-1:0] sy;
		logic [1:0]                    st;
	} proj_t;

	localparam int ATAN_TURN [CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41721, 20860, 10430, 5215,
		2607, 1303, 651, 325, 162, 81};
	localparam longint GAIN_Q30 = 652032874;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [COORD_WIDTH-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic busy, done, pready;
	logic signed [COORD_WIDTH-1:0] screen_x, screen_y;
	logic [1:0] status;
	logic [DATA_W-1:0] prdata;

	perspective_point_projector_unit dut (.*);

	always #5 clk = ~clk;

	// register shadow and derived matrix
	longint shadow_reg [NUM_REGS];
	longint wmat [12];
	proj_t proj_q [$];
	int errors = 0;
	int idle_pct = 0;
	longint cycles = 0;

	function automatic longint fshift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint rshift(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic angle_sincos(input longint ang, output longint c, output longint s);
		longint a, z, x, y, dx, dy;
		int quad;
		a = (ang & ((64'd1 << ANGLE_WIDTH) - 1)) << (32 - ANGLE_WIDTH);
		quad = int'((a >> 30) & 3);
		z = a & 64'h3FFF_FFFF;
		x = GAIN_Q30;
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TURN[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TURN[i];
			end
		end
		x = rshift(x, CORDIC_FRAC - FRAC_BITS);
		y = rshift(y, CORDIC_FRAC - FRAC_BITS);
		case (quad)
			0: begin c = x; s = y; end
			1: begin c = -y; s = x; end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	task automatic rebuild_matrix();
		longint ct, st, cp, sp, acc;
		longint r [9];
		longint h [3];
		longint cam [3];
		angle_sincos(shadow_reg[REG_YAW_ANGLE], ct, st);
		angle_sincos(shadow_reg[REG_PITCH_ANGLE], cp, sp);
		r[0] = rshift(ct * cp, FRAC_BITS);
		r[1] = rshift(ct * sp, FRAC_BITS);
		r[2] = st;
		r[3] = -sp;
		r[4] = cp;
		r[5] = 0;
		r[6] = rshift(-st * cp, FRAC_BITS);
		r[7] = rshift(-st * sp, FRAC_BITS);
		r[8] = ct;
		for (int i = 0; i < 3; i++) begin
			h[i] = -((shadow_reg[i] & ((64'd1 << (COORD_WIDTH - 1)) - 1)) >> 1);
			cam[i] = longint'($signed(shadow_reg[3 + i][COORD_WIDTH-1:0]));
		end
		for (int i = 0; i < 3; i++) begin
			acc = r[3*i] * h[0] + r[3*i+1] * h[1] + r[3*i+2] * h[2];
			for (int j = 0; j < 3; j++)
				wmat[4*i+j] = clamp32(r[3*i+j]);
			wmat[4*i+3] = clamp32(rshift(acc, FRAC_BITS) + cam[i]);
		end
	endtask

	function automatic longint divide_sat(longint num, longint den, ref bit sat);
		longint mag, q, lim;
		mag = num < 0 ? -num : num;
		q = (mag << FRAC_BITS) / den;
		lim = 64'sd1 << (COORD_WIDTH - 1);
		if (num >= 0) begin
			if (q > lim - 1) begin sat = 1; return lim - 1; end
			return q;
		end
		if (q > lim) begin sat = 1; return -lim; end
		return -q;
	endfunction

	function automatic proj_t project_point(longint px, longint py, longint pz);
		proj_t res;
		longint v [3];
		bit sat;
		sat = 0;
		for (int i = 0; i < 3; i++)
			v[i] = rshift(wmat[4*i] * px + wmat[4*i+1] * py + wmat[4*i+2] * pz, FRAC_BITS)
				+ wmat[4*i+3];
		if (v[2] <= 0) begin
			res.sx = '0; res.sy = '0; res.st = ST_DEPTH;
		end else begin
			res.sx = COORD_WIDTH'(divide_sat(v[0], v[2], sat));
			res.sy = COORD_WIDTH'(divide_sat(v[1], v[2], sat));
			res.st = sat ? ST_SAT : ST_OK;
		end
		return res;
	endfunction

	// transfer one point: hold start until the block takes it; busy is looked at
	// mid-cycle, where it shows what the next rising edge sees
	task automatic send_point(input logic [COORD_WIDTH-1:0] x, y, z);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		point_x <= x; point_y <= y; point_z <= z;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		proj_q.insert(proj_q.size(), project_point($signed(x), $signed(y), $signed(z)));
	endtask

	// drain everything in flight, then let the pipeline settle
	task automatic wait_drained();
		start <= 1'b0;
		while (proj_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	// write one register over the APB port, only once no point is in flight
	task automatic write_reg(input int idx, input logic [DATA_W-1:0] val);
		wait_drained();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx < NUM_REGS) begin
			shadow_reg[idx] = val;
			rebuild_matrix();
		end
	endtask

	task automatic send_random(input int n);
		for (int k = 0; k < n; k++)
			send_point(COORD_WIDTH'($urandom), COORD_WIDTH'($urandom),
				COORD_WIDTH'($urandom));
	endtask

	// points mostly in front of the camera, small magnitudes
	task automatic send_near(input int n);
		for (int k = 0; k < n; k++)
			send_point(16'($signed($urandom_range(8191)) - 4096),
				16'($signed($urandom_range(8191)) - 4096),
				16'($signed($urandom_range(8191)) - 4096));
	endtask

	// monitor: compare each strobe with the oldest projection, mid-cycle
	always @(negedge clk) begin
		proj_t exp_p;
		if (arst_n && done) begin
			if (proj_q.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d st=%0d",
					$time, screen_x, screen_y, status);
				errors++;
			end else begin
				exp_p = proj_q.pop_front();
				if (screen_x !== exp_p.sx) begin
					$display("%0t: screen_x expected %0d actual %0d", $time, exp_p.sx, screen_x);
					errors++;
				end
				if (screen_y !== exp_p.sy) begin
					$display("%0t: screen_y expected %0d actual %0d", $time, exp_p.sy, screen_y);
					errors++;
				end
				if (status !== exp_p.st) begin
					$display("%0t: status expected %0d actual %0d", $time, exp_p.st, status);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		logic [15:0] ext [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h1000};
		idle_pct = 0;
		foreach (ext[i]) send_point(ext[i], ext[i], ext[i]);
		send_point(16'h7FFF, 16'h8000, 16'h0000);
		send_point(16'h0000, 16'h0000, 16'h8000);
		// depth not positive with a camera far behind
		write_reg(REG_CAMERA_Z, 32'hFFFF_8000);
		send_point(16'h0100, 16'h0100, 16'h0000);
		send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
		// tiny depth forces saturation
		write_reg(REG_CAMERA_Z, 32'd2048 + 1);
		write_reg(REG_YAW_ANGLE, 32'd0);
		write_reg(REG_PITCH_ANGLE, 32'd0);
		send_point(16'h7FFF, 16'h8000, 16'h0000);
		send_point(16'h8000, 16'h7FFF, 16'h0000);
		// excess register bits
		write_reg(REG_BOX_LENGTH, 32'hFFFF_FFFF);
		send_point(16'h0000, 16'h0000, 16'h0000);
	endtask

	task automatic test_settings();
		logic [DATA_W-1:0] lo_hi [4] = '{32'h0, 32'h7FFF, 32'h8000, 32'hFFFF};
		for (int ph = 0; ph < 4; ph++) begin
			for (int r = 0; r < NUM_REGS; r++)
				write_reg(r, lo_hi[(ph + r) % 4]);
			idle_pct = (ph % 2) ? 78 : 0;
			send_random(50);
		end
	endtask

	task automatic test_random();
		int pcts [4] = '{0, 78, 25, 0};
		for (int ph = 0; ph < 8; ph++) begin
			for (int r = 0; r < NUM_REGS; r++)
				write_reg(r, $urandom);
			write_reg(REG_CAMERA_Z, $urandom_range(32767, 4096));
			idle_pct = pcts[ph % 4];
			send_near(190);
			send_random(40);
			if (ph == 3) wait_drained();
		end
	endtask

	initial begin
		shadow_reg = '{4096, 4096, 4096, 0, 0, 6554, 5461, 910};
		rebuild_matrix();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_random();
		wait_drained();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
